// ----- sv/sacf_pkg.sv -----
// Shared constants of the set-associative cache tag engine with FIFO replacement.
// Used by the channel interfaces and by the top level; depends on nothing.
package sacf_pkg;

  // Default geometry
  localparam int SET_COUNT_DEF  = 64;
  localparam int WAYS_DEF       = 4;
  localparam int ADDR_WIDTH_DEF = 32;

  // Fixed widths of the channel fields
  localparam int ADDR_FIELD_W = 32;
  localparam int TOTAL_W      = 32;

  // Configuration port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 2;
  localparam int OFFSET_W   = 4;
  localparam logic [OFFSET_W-1:0] LINE_OFFSET_RESET = 4'd6;

endpackage

// ----- sv/sacf_ifs.sv -----
// Valid/ready channel interfaces of the cache tag engine: access requests in,
// lookup results out. Field widths come from sacf_pkg.
interface sacf_req_if;
  logic                                valid;
  logic                                ready;
  logic [sacf_pkg::ADDR_FIELD_W-1:0]   access_address;

  modport source (output valid, output access_address, input ready);
  modport sink   (input valid, input access_address, output ready);
endinterface

interface sacf_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                hit;
  logic [sacf_pkg::ADDR_FIELD_W-1:0]   miss_line_address;
  logic                                evicted;
  logic [sacf_pkg::ADDR_FIELD_W-1:0]   victim_line_address;
  logic [sacf_pkg::TOTAL_W-1:0]        hit_total;
  logic [sacf_pkg::TOTAL_W-1:0]        miss_total;

  modport source (output valid, output hit, output miss_line_address, output evicted,
                  output victim_line_address, output hit_total, output miss_total,
                  input ready);
  modport sink   (input valid, input hit, input miss_line_address, input evicted,
                  input victim_line_address, input hit_total, input miss_total,
                  output ready);
endinterface

// ----- sv/set_assoc_cache_fifo_tags.sv -----
// Top level of the set-associative cache tag engine with FIFO replacement.
// Depends on sacf_pkg and the channel interfaces in sacf_ifs.sv.
//
// Takes one read address request per clock while results are taken and returns one
// result per request: the set's tag row and fill/oldest record are read from the
// per-way tag memories and the per-set fill/oldest memory at acceptance, then the
// compare stage checks the ways, picks the insert or victim way and writes back as
// the result register loads, which waits until the result side has room.
// A back-to-back request to the same set sees the previous write through a bypass,
// so the sustained rate is one request per cycle whenever the result side takes one
// per cycle. After reset the block sweeps the per-set fill/oldest memory, one set a
// cycle; request ready stays low until the sweep is done, while the line offset
// register can be written at any time.
module set_assoc_cache_fifo_tags #(
  parameter int SET_COUNT  = sacf_pkg::SET_COUNT_DEF,
  parameter int WAYS       = sacf_pkg::WAYS_DEF,
  parameter int ADDR_WIDTH = sacf_pkg::ADDR_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sacf_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [sacf_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [sacf_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  sacf_req_if.sink                          req,
  sacf_rsp_if.source                        rsp
);

  localparam int SET_BITS = $clog2(SET_COUNT);
  localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CNT_BITS = $clog2(WAYS + 1);
  localparam int POS_W    = WAY_BITS + 1;
  localparam int EXT_W    = (ADDR_WIDTH > sacf_pkg::ADDR_FIELD_W) ? ADDR_WIDTH
                                                                  : sacf_pkg::ADDR_FIELD_W;
  localparam int OW       = sacf_pkg::OFFSET_W;
  localparam int TW       = sacf_pkg::TOTAL_W;

  // ---------------- configuration ----------------
  logic [OW-1:0] line_offset_bits;

  assign pready = 1'b1;
  assign prdata = sacf_pkg::APB_DATA_W'(line_offset_bits);

  // Only one register: every byte address in the window selects it.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_offset_bits <= sacf_pkg::LINE_OFFSET_RESET;
    end else if (psel && penable && pwrite && pready) begin
      line_offset_bits <= pwdata[OW-1:0];
    end
  end

  // ---------------- clearing sweep ----------------
  logic                clr_active;
  logic [SET_BITS-1:0] clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_idx    <= '0;
    end else if (clr_active) begin
      if (clr_idx == SET_BITS'(SET_COUNT - 1)) begin
        clr_active <= 1'b0;
      end
      clr_idx <= clr_idx + 1'b1;
    end
  end

  // ---------------- input side ----------------
  logic [EXT_W-1:0]      addr_wide;
  logic [ADDR_WIDTH-1:0] in_line;
  logic [SET_BITS-1:0]   in_set;
  logic                  in_fire;
  logic                  s_valid;
  logic                  s_go;

  assign addr_wide = EXT_W'(req.access_address);
  assign in_line   = addr_wide[ADDR_WIDTH-1:0] >> line_offset_bits;
  assign in_set    = in_line[SET_BITS-1:0];
  assign req.ready = !clr_active && (!s_valid || s_go);
  assign in_fire   = req.valid && req.ready;

  logic [ADDR_WIDTH-1:0] s_line;
  logic [SET_BITS-1:0]   s_set;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_fire) begin
      s_valid <= 1'b1;
    end else if (s_go) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s_line <= in_line;
      s_set  <= in_set;
    end
  end

  // ---------------- memories ----------------
  logic                  tag_we;
  logic [WAY_BITS-1:0]   wr_way;
  logic [ADDR_WIDTH-1:0] rd_tag [WAYS];

  for (genvar g = 0; g < WAYS; g++) begin : g_way
    logic [ADDR_WIDTH-1:0] tag_mem [SET_COUNT];

    always_ff @(posedge clk) begin
      if (tag_we && wr_way == WAY_BITS'(g)) begin
        tag_mem[s_set] <= s_line;
      end
      if (in_fire) begin
        rd_tag[g] <= tag_mem[in_set];
      end
    end
  end

  logic [CNT_BITS-1:0] fill_mem   [SET_COUNT];
  logic [WAY_BITS-1:0] oldest_mem [SET_COUNT];
  logic                meta_we;
  logic [SET_BITS-1:0] meta_wa;
  logic [CNT_BITS-1:0] meta_fill;
  logic [WAY_BITS-1:0] meta_oldest;
  logic [CNT_BITS-1:0] rd_fill;
  logic [WAY_BITS-1:0] rd_oldest;

  always_ff @(posedge clk) begin
    if (meta_we) begin
      fill_mem[meta_wa]   <= meta_fill;
      oldest_mem[meta_wa] <= meta_oldest;
    end
    if (in_fire) begin
      rd_fill   <= fill_mem[in_set];
      rd_oldest <= oldest_mem[in_set];
    end
  end

  // ---------------- bypass of the last write ----------------
  logic                  wb_valid;
  logic [SET_BITS-1:0]   wb_set;
  logic [WAY_BITS-1:0]   wb_way;
  logic [ADDR_WIDTH-1:0] wb_line;
  logic [CNT_BITS-1:0]   wb_fill;
  logic [WAY_BITS-1:0]   wb_oldest;

  logic                  fwd;
  logic [ADDR_WIDTH-1:0] cur_tag [WAYS];
  logic [CNT_BITS-1:0]   cur_fill;
  logic [WAY_BITS-1:0]   cur_oldest;

  assign fwd = wb_valid && (wb_set == s_set);

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      cur_tag[w] = (fwd && wb_way == WAY_BITS'(w)) ? wb_line : rd_tag[w];
    end
    cur_fill   = fwd ? wb_fill   : rd_fill;
    cur_oldest = fwd ? wb_oldest : rd_oldest;
  end

  // ---------------- lookup and replacement ----------------
  logic [WAYS-1:0]       hit_way;
  logic                  found;
  logic                  full;
  logic [WAY_BITS-1:0]   first_inc;
  logic [POS_W-1:0]      ins_sum;
  logic [POS_W-1:0]      ins_way;
  logic [ADDR_WIDTH-1:0] victim;
  logic [CNT_BITS-1:0]   fill_new;
  logic [WAY_BITS-1:0]   oldest_new;

  always_comb begin
    logic [POS_W-1:0] pos;
    for (int w = 0; w < WAYS; w++) begin
      // place of way w in the ring, counted from the oldest entry
      pos = POS_W'(w) - POS_W'(cur_oldest);
      if (POS_W'(w) < POS_W'(cur_oldest)) begin
        pos = POS_W'(w) + POS_W'(WAYS) - POS_W'(cur_oldest);
      end
      hit_way[w] = (pos < POS_W'(cur_fill)) && (cur_tag[w] == s_line);
    end
  end

  assign found     = |hit_way;
  assign full      = (cur_fill == CNT_BITS'(WAYS));
  assign first_inc = (cur_oldest == WAY_BITS'(WAYS - 1)) ? '0 : cur_oldest + 1'b1;
  assign ins_sum   = POS_W'(cur_oldest) + POS_W'(cur_fill);
  assign ins_way   = (ins_sum >= POS_W'(WAYS)) ? ins_sum - POS_W'(WAYS) : ins_sum;
  assign victim    = cur_tag[cur_oldest];
  assign wr_way    = full ? cur_oldest : ins_way[WAY_BITS-1:0];
  assign fill_new  = full ? cur_fill : cur_fill + 1'b1;
  assign oldest_new = full ? first_inc : cur_oldest;

  assign s_go   = s_valid && (!rsp.valid || rsp.ready);
  assign tag_we = s_go && !found;

  always_comb begin
    if (clr_active) begin
      meta_we     = 1'b1;
      meta_wa     = clr_idx;
      meta_fill   = '0;
      meta_oldest = '0;
    end else begin
      meta_we     = s_go && !found;
      meta_wa     = s_set;
      meta_fill   = fill_new;
      meta_oldest = oldest_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid <= 1'b0;
    end else if (s_go) begin
      wb_valid <= !found;
    end
  end

  always_ff @(posedge clk) begin
    if (s_go) begin
      wb_set    <= s_set;
      wb_way    <= wr_way;
      wb_line   <= s_line;
      wb_fill   <= fill_new;
      wb_oldest <= oldest_new;
    end
  end

  // ---------------- counters and result register ----------------
  logic [TW-1:0]    hit_counter;
  logic [TW-1:0]    miss_counter;
  logic [TW-1:0]    hit_counter_next;
  logic [TW-1:0]    miss_counter_next;
  logic [EXT_W-1:0] line_wide;
  logic [EXT_W-1:0] victim_wide;
  logic             rsp_valid;

  assign hit_counter_next  = hit_counter  + TW'(found);
  assign miss_counter_next = miss_counter + TW'(!found);
  assign line_wide         = EXT_W'(s_line);
  assign victim_wide       = EXT_W'(victim);

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_counter  <= '0;
      miss_counter <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      if (s_go) begin
        hit_counter  <= hit_counter_next;
        miss_counter <= miss_counter_next;
        rsp_valid    <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_go) begin
      rsp.hit                 <= found;
      rsp.miss_line_address   <= found ? '0 : line_wide[sacf_pkg::ADDR_FIELD_W-1:0];
      rsp.evicted             <= !found && full;
      rsp.victim_line_address <= (!found && full) ? victim_wide[sacf_pkg::ADDR_FIELD_W-1:0]
                                                  : '0;
      rsp.hit_total           <= hit_counter_next;
      rsp.miss_total          <= miss_counter_next;
    end
  end

  assign rsp.valid = rsp_valid;

  // ---------------- assertions ----------------
  a_no_req_during_clear: assert property (@(posedge clk) disable iff (rst)
    clr_active |-> !req.ready)
    else $error("request taken during clearing sweep");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.hit |-> !rsp.evicted && rsp.miss_line_address == '0)
    else $error("hit result reports a miss or eviction");

  a_counters_step: assert property (@(posedge clk) disable iff (rst)
    s_go |=> TW'(hit_counter + miss_counter) ==
             TW'($past(hit_counter) + $past(miss_counter) + TW'(1)))
    else $error("hit/miss counters did not advance by one");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    meta_we && !clr_active |-> meta_fill <= CNT_BITS'(WAYS) && meta_fill != '0)
    else $error("set fill count out of range");

endmodule
